[rtl/core/antipodal_grasp_pair_check_assert.svh]
// Assertion macros shared by the grasp pair check checker.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef ANTIPODAL_GRASP_PAIR_CHECK_ASSERT_SVH
`define ANTIPODAL_GRASP_PAIR_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define AGP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define AGP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/agp_pkg.sv]
// Shared types, widths, latencies and constants of the grasp pair check.
// Depends on nothing; every RTL module imports it.
`default_nettype none

package agp_pkg;

    // Field types.
    typedef logic signed [15:0] t_coord;
    typedef logic signed [15:0] t_normal;

    localparam int WIDTH_W   = 17;
    localparam int TOL_W     = 12;
    localparam int QUAL_W    = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [WIDTH_W-1:0] t_width;
    typedef logic [TOL_W-1:0]   t_tol;
    typedef logic [QUAL_W-1:0]  t_quality;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_MAX_WIDTH   = 2'd0;
    localparam t_cfg_idx CFG_VOXEL_TOL   = 2'd1;
    localparam t_cfg_idx CFG_MIN_QUALITY = 2'd2;

    localparam t_width   MAX_WIDTH_RST   = 17'd410;
    localparam t_tol     VOXEL_TOL_RST   = 12'd41;
    localparam t_quality MIN_QUALITY_RST = 16'd38400;

    typedef enum logic [1:0] {
        REJ_NONE        = 2'd0,
        REJ_WIDE        = 2'd1,
        REJ_LOW_QUALITY = 2'd2,
        REJ_DEGENERATE  = 2'd3
    } t_reject;

    // Pipelined square root: one result bit per stage plus a rounding stage.
    localparam int SQ_RAD_W  = 54;
    localparam int SQ_STEPS  = SQ_RAD_W / 2;
    localparam int SQ_ROOT_W = SQ_STEPS + 1;
    localparam int SQ_REM_W  = SQ_STEPS + 3;
    localparam int SQ_LAT    = SQ_STEPS + 1;

    // Scale applied before the magnitude roots.
    localparam int NORM_SHIFT = 20;

    // Magnitudes and the denominator product.
    localparam int MD_W     = 27;
    localparam int MN_W     = 26;
    localparam int MN_LO_W  = 13;
    localparam int PP_W     = MD_W + MN_LO_W;
    localparam int DEN_W    = MD_W + MN_W;
    localparam int DOT_W    = 35;
    localparam int MAG_W    = 35;

    // Cosine divider.
    localparam int COS_W     = 17;
    localparam int DIV_SHIFT = 36;
    localparam int DIV_NUM_W = MAG_W + DIV_SHIFT;
    localparam int DIV_STEPS = COS_W;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam logic [COS_W-1:0] COS_ONE = 17'd65536;

    // Angle unit: square, subtract, root, CORDIC, round.
    localparam int CORDIC_STEPS = 16;
    localparam int CRD_W        = 34;
    localparam int ZACC_W       = 25;
    localparam int ATAN_W       = 22;
    localparam int ANG_W        = 15;
    localparam int CRD_SHIFT    = 14;
    localparam int ANG_LAT      = 2 + SQ_LAT + CORDIC_STEPS + 1;
    localparam logic [ANG_W-1:0] ANGLE_MAX = 15'd23040;

    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117306,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115
    };

    localparam t_quality QUALITY_FULL = 16'd46080;
    localparam t_width   WIDTH_MAX    = 17'd131071;

    // Whole pipeline: front end, roots, width and product, divider, angle, output.
    localparam int FRONT_LAT  = 3;
    localparam int SIDE_DLY   = DIV_LAT + ANG_LAT;
    localparam int MAG_DLY    = SQ_LAT + 2;
    localparam int PIPE_DEPTH = FRONT_LAT + SQ_LAT + 2 + SIDE_DLY + 1;

    typedef struct packed {
        t_width width;
        logic   wide;
        logic   degen;
    } t_side;

endpackage

`default_nettype wire

[rtl/core/agp_sqrt.sv]
// Pipelined rounded integer square root, one root bit per stage.
// Depends on agp_pkg for its widths and latency.
`default_nettype none

module agp_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [agp_pkg::SQ_RAD_W-1:0]   i_rad,
    output logic [agp_pkg::SQ_ROOT_W-1:0]  o_root
);
    import agp_pkg::*;

    logic [SQ_RAD_W-1:0] r_rad [SQ_STEPS];
    logic [SQ_REM_W-1:0] r_rem [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_q   [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] r_root;

    logic [SQ_RAD_W-1:0] rad_in [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_in [SQ_STEPS];
    logic [SQ_STEPS-1:0] q_in   [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_sh [SQ_STEPS];
    logic [SQ_REM_W-1:0] trial  [SQ_STEPS];
    logic [SQ_RAD_W-1:0] n_rad  [SQ_STEPS];
    logic [SQ_REM_W-1:0] n_rem  [SQ_STEPS];
    logic [SQ_STEPS-1:0] n_q    [SQ_STEPS];
    logic [SQ_ROOT_W-1:0] n_root;

    // Each stage brings down two radicand bits and tries the next root bit.
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                rad_in[k] = i_rad;
                rem_in[k] = '0;
                q_in[k]   = '0;
            end else begin
                rad_in[k] = r_rad[k-1];
                rem_in[k] = r_rem[k-1];
                q_in[k]   = r_q[k-1];
            end
            rem_sh[k] = {rem_in[k][SQ_REM_W-3:0], rad_in[k][SQ_RAD_W-1 -: 2]};
            trial[k]  = {{(SQ_REM_W-SQ_STEPS-2){1'b0}}, q_in[k], 2'b01};
            n_rad[k]  = rad_in[k] << 2;
            if (rem_sh[k] >= trial[k]) begin
                n_rem[k] = rem_sh[k] - trial[k];
                n_q[k]   = {q_in[k][SQ_STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = rem_sh[k];
                n_q[k]   = {q_in[k][SQ_STEPS-2:0], 1'b0};
            end
        end
        // The remainder is radicand minus root squared; round up when it exceeds the root.
        n_root = SQ_ROOT_W'(r_q[SQ_STEPS-1])
               + SQ_ROOT_W'(r_rem[SQ_STEPS-1] > SQ_REM_W'(r_q[SQ_STEPS-1]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_rad[k] <= n_rad[k];
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
            r_root <= n_root;
        end
    end

    assign o_root = r_root;

endmodule

`default_nettype wire

[rtl/core/agp_cdiv.sv]
// Pipelined restoring divider giving the Q16 cosine, clamped to one.
// Depends on agp_pkg for its widths and latency.
`default_nettype none

module agp_cdiv (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [agp_pkg::MAG_W-1:0]  i_mag,
    input  logic [agp_pkg::DEN_W-1:0]  i_den,
    output logic [agp_pkg::COS_W-1:0]  o_cos
);
    import agp_pkg::*;

    logic [DIV_NUM_W-1:0] r0_rem;
    logic [DEN_W-1:0]     r0_den;
    logic                 r0_sat;

    logic [DIV_NUM_W-1:0] r_rem [DIV_STEPS];
    logic [DEN_W-1:0]     r_den [DIV_STEPS];
    logic [COS_W-1:0]     r_q   [DIV_STEPS];
    logic                 r_sat [DIV_STEPS];
    logic [COS_W-1:0]     r_cos;

    logic [DIV_NUM_W-1:0] n0_rem;
    logic [DIV_NUM_W-1:0] rem_in [DIV_STEPS];
    logic [DEN_W-1:0]     den_in [DIV_STEPS];
    logic [COS_W-1:0]     q_in   [DIV_STEPS];
    logic                 sat_in [DIV_STEPS];
    logic [DIV_NUM_W-1:0] sub    [DIV_STEPS];
    logic [DIV_NUM_W-1:0] n_rem  [DIV_STEPS];
    logic [COS_W-1:0]     n_q    [DIV_STEPS];
    logic [COS_W-1:0]     n_cos;

    always_comb begin
        n0_rem = {i_mag, {DIV_SHIFT{1'b0}}};
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in[k] = r0_rem;
                den_in[k] = r0_den;
                q_in[k]   = '0;
                sat_in[k] = r0_sat;
            end else begin
                rem_in[k] = r_rem[k-1];
                den_in[k] = r_den[k-1];
                q_in[k]   = r_q[k-1];
                sat_in[k] = r_sat[k-1];
            end
            sub[k] = DIV_NUM_W'(den_in[k]) << (DIV_STEPS - 1 - k);
            if (rem_in[k] >= sub[k]) begin
                n_rem[k] = rem_in[k] - sub[k];
                n_q[k]   = q_in[k] | (COS_W'(1) << (DIV_STEPS - 1 - k));
            end else begin
                n_rem[k] = rem_in[k];
                n_q[k]   = q_in[k];
            end
        end
        if (r_sat[DIV_STEPS-1] || (r_q[DIV_STEPS-1] > COS_ONE)) begin
            n_cos = COS_ONE;
        end else begin
            n_cos = r_q[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // A quotient that would need more than the available bits clamps to one.
            r0_sat <= n0_rem >= DIV_NUM_W'({i_den, {DIV_STEPS{1'b0}}});
            r0_rem <= n0_rem;
            r0_den <= i_den;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= den_in[k];
                r_q[k]   <= n_q[k];
                r_sat[k] <= sat_in[k];
            end
            r_cos <= n_cos;
        end
    end

    assign o_cos = r_cos;

endmodule

`default_nettype wire

[rtl/core/agp_angle.sv]
// Contact angle unit: sine from the cosine, then a pipelined CORDIC atan2 in degrees.
// Depends on agp_pkg and instantiates agp_sqrt.
`default_nettype none

module agp_angle (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [agp_pkg::COS_W-1:0]  i_cos,
    output logic [agp_pkg::ANG_W-1:0]  o_angle
);
    import agp_pkg::*;

    localparam int CSQ_W = 2 * COS_W;
    localparam int ARG_W = 33;

    logic [COS_W-1:0]  r_c0;
    logic [CSQ_W-1:0]  r_csq;
    logic [COS_W-1:0]  r_c1;
    logic [ARG_W-1:0]  r_arg;
    logic [COS_W-1:0]  r_cd [SQ_LAT];
    logic [SQ_ROOT_W-1:0] s_root;

    logic signed [CRD_W-1:0]  r_x [CORDIC_STEPS];
    logic signed [CRD_W-1:0]  r_y [CORDIC_STEPS];
    logic signed [ZACC_W-1:0] r_z [CORDIC_STEPS];
    logic [ANG_W-1:0]         r_angle;

    logic signed [CRD_W-1:0]  x_in [CORDIC_STEPS];
    logic signed [CRD_W-1:0]  y_in [CORDIC_STEPS];
    logic signed [ZACC_W-1:0] z_in [CORDIC_STEPS];
    logic signed [ZACC_W-1:0] step [CORDIC_STEPS];
    logic signed [CRD_W-1:0]  n_x  [CORDIC_STEPS];
    logic signed [CRD_W-1:0]  n_y  [CORDIC_STEPS];
    logic signed [ZACC_W-1:0] n_z  [CORDIC_STEPS];
    logic [ZACC_W-1:0]        z_rnd;
    logic [ZACC_W-1:0]        z_q88;
    logic [ANG_W-1:0]         n_angle;

    agp_sqrt u_sq_sin (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (SQ_RAD_W'(r_arg)),
        .o_root (s_root)
    );

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (k == 0) begin
                x_in[k] = CRD_W'({r_cd[SQ_LAT-1], {CRD_SHIFT{1'b0}}});
                y_in[k] = CRD_W'({s_root[COS_W-1:0], {CRD_SHIFT{1'b0}}});
                z_in[k] = '0;
            end else begin
                x_in[k] = r_x[k-1];
                y_in[k] = r_y[k-1];
                z_in[k] = r_z[k-1];
            end
            step[k] = ZACC_W'($signed({1'b0, ATAN_DEG_Q16[k]}));
            // Rotate toward the x axis; the shifts round toward minus infinity.
            if (!y_in[k][CRD_W-1]) begin
                n_x[k] = x_in[k] + (y_in[k] >>> k);
                n_y[k] = y_in[k] - (x_in[k] >>> k);
                n_z[k] = z_in[k] + step[k];
            end else begin
                n_x[k] = x_in[k] - (y_in[k] >>> k);
                n_y[k] = y_in[k] + (x_in[k] >>> k);
                n_z[k] = z_in[k] - step[k];
            end
        end
        // Negative angles clamp to zero, then Q16 rounds to Q7.8 and clamps at 90 degrees.
        if (r_z[CORDIC_STEPS-1][ZACC_W-1]) begin
            z_rnd = '0;
        end else begin
            z_rnd = ZACC_W'(r_z[CORDIC_STEPS-1]) + ZACC_W'(128);
        end
        z_q88 = z_rnd >> 8;
        if (z_q88 > ZACC_W'(ANGLE_MAX)) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = z_q88[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0  <= i_cos;
            r_csq <= CSQ_W'(i_cos) * CSQ_W'(i_cos);
            r_c1  <= r_c0;
            r_arg <= (ARG_W'(1) << 32) - ARG_W'(r_csq);
            for (int k = 0; k < SQ_LAT; k++) begin
                if (k == 0) begin
                    r_cd[k] <= r_c1;
                end else begin
                    r_cd[k] <= r_cd[k-1];
                end
            end
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

[rtl/core/antipodal_grasp_pair_check.sv]
// Antipodal grasp pair check, top level.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// Depends on agp_pkg; instantiates agp_sqrt, agp_cdiv and agp_angle.
`default_nettype none

module antipodal_grasp_pair_check (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  agp_pkg::t_coord    i_first_x,
    input  agp_pkg::t_coord    i_first_y,
    input  agp_pkg::t_coord    i_first_z,
    input  agp_pkg::t_coord    i_second_x,
    input  agp_pkg::t_coord    i_second_y,
    input  agp_pkg::t_coord    i_second_z,
    input  agp_pkg::t_normal   i_first_nx,
    input  agp_pkg::t_normal   i_first_ny,
    input  agp_pkg::t_normal   i_first_nz,
    input  agp_pkg::t_normal   i_second_nx,
    input  agp_pkg::t_normal   i_second_ny,
    input  agp_pkg::t_normal   i_second_nz,

    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_accepted,
    output logic [1:0]         o_reject_code,
    output agp_pkg::t_width    o_grip_width,
    output agp_pkg::t_quality  o_grasp_quality,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  agp_pkg::t_cfg_idx  i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import agp_pkg::*;

    // The pipeline moves as one: every stage advances unless a finished
    // result sits at the output and the consumer stalls it.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Configuration registers. The user must write them only while the pipe is empty; the block does not enforce it.
    t_width   r_cfg_max;
    t_tol     r_cfg_tol;
    t_quality r_cfg_minq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_max  <= MAX_WIDTH_RST;
            r_cfg_tol  <= VOXEL_TOL_RST;
            r_cfg_minq <= MIN_QUALITY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_WIDTH:   r_cfg_max  <= i_cfg_data;
                CFG_VOXEL_TOL:   r_cfg_tol  <= i_cfg_data[TOL_W-1:0];
                CFG_MIN_QUALITY: r_cfg_minq <= i_cfg_data[QUAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel beside the data; the last one is the output valid.
    logic [PIPE_DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];

    // Stage 1: difference vector and the two normals.
    logic signed [16:0] r1_d  [3];
    logic signed [15:0] r1_n1 [3];
    logic signed [15:0] r1_n2 [3];

    // Stage 2: the products of the dot products and squared lengths.
    logic [32:0]        r2_dsq [3];
    logic signed [32:0] r2_dn1 [3];
    logic signed [32:0] r2_dn2 [3];
    logic [30:0]        r2_nsq1 [3];
    logic [30:0]        r2_nsq2 [3];
    logic               r2_degen;

    // Stage 3: sums.
    logic [33:0]             r3_dd;
    logic signed [DOT_W-1:0] r3_dot1;
    logic signed [DOT_W-1:0] r3_dot2;
    logic [31:0]             r3_nn1;
    logic [31:0]             r3_nn2;
    logic                    r3_degen;

    logic signed [33:0] p_dsq  [3];
    logic signed [32:0] p_dn1  [3];
    logic signed [32:0] p_dn2  [3];
    logic signed [31:0] p_nsq1 [3];
    logic signed [31:0] p_nsq2 [3];
    logic               degen_now;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_dsq[i]  = r1_d[i] * r1_d[i];
            p_dn1[i]  = r1_d[i] * r1_n1[i];
            p_dn2[i]  = r1_d[i] * r1_n2[i];
            p_nsq1[i] = r1_n1[i] * r1_n1[i];
            p_nsq2[i] = r1_n2[i] * r1_n2[i];
        end
        // Coincident points, or a normal that is all zero, have no defined angle.
        degen_now = ((r1_d[0] == '0) && (r1_d[1] == '0) && (r1_d[2] == '0))
                 || ((r1_n1[0] == '0) && (r1_n1[1] == '0) && (r1_n1[2] == '0))
                 || ((r1_n2[0] == '0) && (r1_n2[1] == '0) && (r1_n2[2] == '0));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0]  <= 17'(i_first_x) - 17'(i_second_x);
            r1_d[1]  <= 17'(i_first_y) - 17'(i_second_y);
            r1_d[2]  <= 17'(i_first_z) - 17'(i_second_z);
            r1_n1[0] <= i_first_nx;
            r1_n1[1] <= i_first_ny;
            r1_n1[2] <= i_first_nz;
            r1_n2[0] <= i_second_nx;
            r1_n2[1] <= i_second_ny;
            r1_n2[2] <= i_second_nz;

            for (int i = 0; i < 3; i++) begin
                r2_dsq[i]  <= p_dsq[i][32:0];
                r2_dn1[i]  <= p_dn1[i];
                r2_dn2[i]  <= p_dn2[i];
                r2_nsq1[i] <= p_nsq1[i][30:0];
                r2_nsq2[i] <= p_nsq2[i][30:0];
            end
            r2_degen <= degen_now;

            r3_dd    <= 34'(r2_dsq[0]) + 34'(r2_dsq[1]) + 34'(r2_dsq[2]);
            r3_dot1  <= DOT_W'(r2_dn1[0]) + DOT_W'(r2_dn1[1]) + DOT_W'(r2_dn1[2]);
            r3_dot2  <= DOT_W'(r2_dn2[0]) + DOT_W'(r2_dn2[1]) + DOT_W'(r2_dn2[2]);
            r3_nn1   <= 32'(r2_nsq1[0]) + 32'(r2_nsq1[1]) + 32'(r2_nsq1[2]);
            r3_nn2   <= 32'(r2_nsq2[0]) + 32'(r2_nsq2[1]) + 32'(r2_nsq2[2]);
            r3_degen <= r2_degen;
        end
    end

    // Four roots in parallel: the plain distance for the grip width, and the
    // scaled magnitudes of the difference and of each normal for the cosines.
    logic [SQ_ROOT_W-1:0] root_w;
    logic [SQ_ROOT_W-1:0] root_md;
    logic [SQ_ROOT_W-1:0] root_mn1;
    logic [SQ_ROOT_W-1:0] root_mn2;

    agp_sqrt u_sq_width (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_RAD_W'(r3_dd)),
        .o_root (root_w)
    );

    agp_sqrt u_sq_md (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  ({r3_dd, {NORM_SHIFT{1'b0}}}),
        .o_root (root_md)
    );

    agp_sqrt u_sq_mn1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_RAD_W'({r3_nn1, {NORM_SHIFT{1'b0}}})),
        .o_root (root_mn1)
    );

    agp_sqrt u_sq_mn2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (SQ_RAD_W'({r3_nn2, {NORM_SHIFT{1'b0}}})),
        .o_root (root_mn2)
    );

    // The degenerate flag waits out the roots; the dot magnitudes wait out
    // the roots and the denominator product.
    logic             r_degen_dly [SQ_LAT];
    logic [MAG_W-1:0] r_mag1_dly  [MAG_DLY];
    logic [MAG_W-1:0] r_mag2_dly  [MAG_DLY];
    logic [MAG_W-1:0] mag1_now;
    logic [MAG_W-1:0] mag2_now;

    assign mag1_now = r3_dot1[DOT_W-1] ? MAG_W'(-r3_dot1) : MAG_W'(r3_dot1);
    assign mag2_now = r3_dot2[DOT_W-1] ? MAG_W'(-r3_dot2) : MAG_W'(r3_dot2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < SQ_LAT; k++) begin
                if (k == 0) begin
                    r_degen_dly[k] <= r3_degen;
                end else begin
                    r_degen_dly[k] <= r_degen_dly[k-1];
                end
            end
            for (int k = 0; k < MAG_DLY; k++) begin
                if (k == 0) begin
                    r_mag1_dly[k] <= mag1_now;
                    r_mag2_dly[k] <= mag2_now;
                end else begin
                    r_mag1_dly[k] <= r_mag1_dly[k-1];
                    r_mag2_dly[k] <= r_mag2_dly[k-1];
                end
            end
        end
    end

    // Grip width with tolerance and saturation, and each denominator product,
    // built from two partial products split on the normal magnitude, then summed.
    t_side             r_side_a;
    t_side             r_side_b;
    logic [PP_W-1:0]   r_plo1;
    logic [PP_W-1:0]   r_phi1;
    logic [PP_W-1:0]   r_plo2;
    logic [PP_W-1:0]   r_phi2;
    logic [DEN_W-1:0]  r_den1;
    logic [DEN_W-1:0]  r_den2;

    logic [WIDTH_W:0]  width_sum;
    t_side             side_now;

    always_comb begin
        width_sum = (WIDTH_W+1)'(root_w[WIDTH_W-1:0]) + (WIDTH_W+1)'(r_cfg_tol);
        if (width_sum > (WIDTH_W+1)'(WIDTH_MAX)) begin
            side_now.width = WIDTH_MAX;
        end else begin
            side_now.width = width_sum[WIDTH_W-1:0];
        end
        side_now.wide  = side_now.width > r_cfg_max;
        side_now.degen = r_degen_dly[SQ_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_a <= side_now;
            r_plo1   <= PP_W'(root_md[MD_W-1:0]) * PP_W'(root_mn1[MN_LO_W-1:0]);
            r_phi1   <= PP_W'(root_md[MD_W-1:0]) * PP_W'(root_mn1[MN_W-1:MN_LO_W]);
            r_plo2   <= PP_W'(root_md[MD_W-1:0]) * PP_W'(root_mn2[MN_LO_W-1:0]);
            r_phi2   <= PP_W'(root_md[MD_W-1:0]) * PP_W'(root_mn2[MN_W-1:MN_LO_W]);

            r_side_b <= r_side_a;
            r_den1   <= DEN_W'(r_plo1) + (DEN_W'(r_phi1) << MN_LO_W);
            r_den2   <= DEN_W'(r_plo2) + (DEN_W'(r_phi2) << MN_LO_W);
        end
    end

    // Cosine of each contact, then its angle.
    logic [COS_W-1:0] cos1;
    logic [COS_W-1:0] cos2;
    logic [ANG_W-1:0] angle1;
    logic [ANG_W-1:0] angle2;

    agp_cdiv u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_mag1_dly[MAG_DLY-1]),
        .i_den (r_den1),
        .o_cos (cos1)
    );

    agp_cdiv u_div2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (r_mag2_dly[MAG_DLY-1]),
        .i_den (r_den2),
        .o_cos (cos2)
    );

    agp_angle u_ang1 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cos   (cos1),
        .o_angle (angle1)
    );

    agp_angle u_ang2 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cos   (cos2),
        .o_angle (angle2)
    );

    // Width and flags ride alongside the divider and angle units.
    t_side r_side_dly [SIDE_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < SIDE_DLY; k++) begin
                if (k == 0) begin
                    r_side_dly[k] <= r_side_b;
                end else begin
                    r_side_dly[k] <= r_side_dly[k-1];
                end
            end
        end
    end

    // Output stage. A too wide pair is reported first, then a degenerate
    // one; both show zero quality. Otherwise the quality decides.
    t_side    side_out;
    t_quality quality;
    t_reject  n_code;
    t_quality n_quality;

    always_comb begin
        side_out = r_side_dly[SIDE_DLY-1];
        quality  = QUALITY_FULL - QUAL_W'(angle1) - QUAL_W'(angle2);
        if (side_out.wide) begin
            n_code    = REJ_WIDE;
            n_quality = '0;
        end else if (side_out.degen) begin
            n_code    = REJ_DEGENERATE;
            n_quality = '0;
        end else if (quality < r_cfg_minq) begin
            n_code    = REJ_LOW_QUALITY;
            n_quality = quality;
        end else begin
            n_code    = REJ_NONE;
            n_quality = quality;
        end
    end

    t_reject  r_code;
    t_width   r_width;
    t_quality r_quality;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_code    <= n_code;
            r_width   <= side_out.width;
            r_quality <= n_quality;
        end
    end

    assign o_accepted      = (r_code == REJ_NONE);
    assign o_reject_code   = r_code;
    assign o_grip_width    = r_width;
    assign o_grasp_quality = r_quality;

endmodule

`default_nettype wire

[rtl/core/agp_check.sv]
// Port-level checker for the grasp pair check, bound to the top level.
// Depends on agp_pkg and the assertion macro header.
`default_nettype none
`include "antipodal_grasp_pair_check_assert.svh"

module agp_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_valid,
    input logic               o_stall,
    input logic               o_accepted,
    input logic [1:0]         o_reject_code,
    input agp_pkg::t_width    o_grip_width,
    input agp_pkg::t_quality  o_grasp_quality
);
    import agp_pkg::*;

    // The accepted flag and the reject code must agree.
    `AGP_ASSERT_IMP(a_accept_code, o_valid, o_accepted == (o_reject_code == REJ_NONE), "accepted flag disagrees with code")

    // Width and degenerate rejects report no quality.
    `AGP_ASSERT_IMP(a_zero_quality, o_valid && (o_reject_code == REJ_WIDE || o_reject_code == REJ_DEGENERATE), o_grasp_quality == '0, "quality shown on a width or degenerate reject")

    // A blocked result backs the whole pipeline up to the input.
    `AGP_ASSERT_IMP(a_stall_back, o_valid && i_stall, o_stall, "input not stalled while a result is blocked")

    // A blocked result stays on the port unchanged.
    `AGP_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_grip_width) && $stable(o_grasp_quality), "blocked result changed")

endmodule

bind antipodal_grasp_pair_check agp_check u_agp_check (.*);

`default_nettype wire
